// ----- hdl/aac_pkg.sv -----
// Shared types and constants for the accelerometer activity classifier.
package aac_pkg;

  // Activity level codes.
  localparam logic [1:0] LEVEL_INACTIVE = 2'd0;
  localparam logic [1:0] LEVEL_ACTIVE   = 2'd1;
  localparam logic [1:0] LEVEL_HIGH     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;

  // Threshold reset values, mean magnitude in counts at 4 mg per count.
  localparam logic [15:0] HIGH_THRESHOLD_RST = 16'd400;
  localparam logic [15:0] LOW_THRESHOLD_RST  = 16'd288;

  // The window sum output saturates at its full 20-bit range.
  localparam int unsigned WSUM_W = 20;
  localparam logic [WSUM_W-1:0] WSUM_MAX = 20'hFFFFF;

  // Status from the magnitude unit.
  typedef struct packed {
    logic        done;
    logic [15:0] magnitude;
  } mag_status_t;

  // Status from the window unit.
  typedef struct packed {
    logic              done;
    logic [1:0]        level;
    logic [WSUM_W-1:0] window_sum;
  } win_status_t;

endpackage

// ----- hdl/accel_activity_classifier.sv -----
// Top level of the accelerometer activity classifier.
//
//   Channel   Handshake                      Payload
//   sample    sample_valid / sample_stall    accel_x, accel_y, accel_z
//   result    result_valid / result_stall    activity_level, magnitude, window_sum
//   config    cfg_write_en                   cfg_index, cfg_data
//
// A sample passes from its transfer through the shared squaring multiplier, the
// bit-per-cycle square root, the ring read, sum update and classification, and is
// then loaded into the output register. The next sample can be taken only once that
// result is loaded, so one sample is in flight at a time.
// sample_stall stays high from the transfer until the result is loaded into the output
// register. A stalled result waits in that register; the next sample is then taken
// while it waits, and its result is loaded once the old one is transferred.
// Reset clears the ring through per-entry valid bits at once, so no clearing pass runs.
module accel_activity_classifier #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic signed [15:0]              accel_x,
  input  logic signed [15:0]              accel_y,
  input  logic signed [15:0]              accel_z,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      activity_level,
  output logic [15:0]                     magnitude,
  output logic [aac_pkg::WSUM_W-1:0]      window_sum,
  input  logic                            cfg_write_en,
  input  logic [aac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import aac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAG  = 4'b0010,
    S_WIN  = 4'b0100,
    S_HOLD = 4'b1000
  } top_state_t;

  top_state_t  state;
  logic        sample_take;
  logic        win_start;
  logic        out_free;
  logic        out_load;
  logic [15:0] high_threshold;
  logic [15:0] low_threshold;
  mag_status_t mag_status;
  win_status_t win_status;

  assign sample_stall = (state != S_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  assign win_start    = (state == S_MAG) && mag_status.done;
  assign out_free     = !result_valid || !result_stall;
  assign out_load     = (((state == S_WIN) && win_status.done) || (state == S_HOLD))
                        && out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HIGH_THRESHOLD_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_take) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          if (mag_status.done) begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_status.done) begin
            state <= out_load ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      activity_level <= win_status.level;
      magnitude      <= mag_status.magnitude;
      window_sum     <= win_status.window_sum;
    end
  end

  aac_magnitude u_magnitude (
    .clk     (clk),
    .rst     (rst),
    .start   (sample_take),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .status  (mag_status)
  );

  aac_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .start          (win_start),
    .magnitude      (mag_status.magnitude),
    .high_threshold (high_threshold),
    .low_threshold  (low_threshold),
    .status         (win_status)
  );

endmodule

// ----- hdl/aac_magnitude.sv -----
// Vector magnitude: shared squaring multiplier and iterative floor square root.
module aac_magnitude (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  output aac_pkg::mag_status_t status
);
  import aac_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE   = 3'b001,
    M_SQUARE = 3'b010,
    M_ROOT   = 3'b100
  } mag_state_t;

  mag_state_t  state;
  logic [15:0] abs_x;
  logic [15:0] abs_y;
  logic [15:0] abs_z;
  logic [1:0]  sq_cnt;
  logic [3:0]  rt_cnt;
  logic [15:0] operand;
  logic [31:0] prod;
  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] rem;
  logic [31:0] root;
  logic [31:0] bit_q;
  logic [32:0] trial;
  logic        done;

  // Magnitude of a two's complement value; the most negative value maps to 32768.
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  // Operand select for the shared multiplier.
  always_comb begin
    case (sq_cnt)
      2'd0:    operand = abs_x;
      2'd1:    operand = abs_y;
      default: operand = abs_z;
    endcase
  end

  assign acc_next = acc + prod;
  assign trial    = {1'b0, root} + {1'b0, bit_q};

  // Sequencer: three squares into the accumulator, then sixteen root steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= M_IDLE;
      sq_cnt <= '0;
      rt_cnt <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            sq_cnt <= '0;
            state  <= M_SQUARE;
          end
        end
        M_SQUARE: begin
          sq_cnt <= sq_cnt + 2'd1;
          if (sq_cnt == 2'd3) begin
            rt_cnt <= '0;
            state  <= M_ROOT;
          end
        end
        M_ROOT: begin
          rt_cnt <= rt_cnt + 4'd1;
          if (rt_cnt == 4'd15) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (start) begin
          abs_x <= abs16(accel_x);
          abs_y <= abs16(accel_y);
          abs_z <= abs16(accel_z);
          acc   <= '0;
        end
      end
      M_SQUARE: begin
        prod <= operand * operand;
        if (sq_cnt != 2'd0) begin
          acc <= acc_next;
        end
        if (sq_cnt == 2'd3) begin
          rem   <= acc_next;
          root  <= '0;
          bit_q <= 32'h4000_0000;
        end
      end
      M_ROOT: begin
        // One digit per cycle of the digit-by-digit square root.
        if ({1'b0, rem} >= trial) begin
          rem  <= rem - trial[31:0];
          root <= (root >> 1) + bit_q;
        end else begin
          root <= root >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign status.done      = done;
  assign status.magnitude = root[15:0];

endmodule

// ----- hdl/aac_window.sv -----
// Magnitude ring, running sum and threshold classification.
module aac_window #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [15:0]         magnitude,
  input  logic [15:0]         high_threshold,
  input  logic [15:0]         low_threshold,
  output aac_pkg::win_status_t status
);
  import aac_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = 16 + $clog2(WINDOW);
  localparam int unsigned EXT_W  = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;

  typedef enum logic [2:0] {
    W_IDLE     = 3'b001,
    W_UPDATE   = 3'b010,
    W_CLASSIFY = 3'b100
  } win_state_t;

  win_state_t        state;
  logic [15:0]       ring_mem [WINDOW];
  logic [WINDOW-1:0] valid;
  logic [SLOT_W-1:0] slot;
  logic [15:0]       rd_data;
  logic              rd_valid;
  logic [15:0]       mag_q;
  logic [15:0]       old_mag;
  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W-1:0]  hi_lim;
  logic [SUM_W-1:0]  lo_lim;
  logic [EXT_W-1:0]  sum_ext;
  logic              done;
  logic [1:0]        level;
  logic [WSUM_W-1:0] sum_out;

  assign old_mag = rd_valid ? rd_data : 16'd0;
  assign sum_ext = EXT_W'(running_sum);

  // Ring memory: read the outgoing entry, then overwrite it.
  always_ff @(posedge clk) begin
    if (state == W_IDLE && start) begin
      rd_data <= ring_mem[slot];
    end
    if (state == W_UPDATE) begin
      ring_mem[slot] <= mag_q;
    end
  end

  // Control, entry valid bits and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= W_IDLE;
      valid       <= '0;
      slot        <= '0;
      running_sum <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            state <= W_UPDATE;
          end
        end
        W_UPDATE: begin
          running_sum <= running_sum - SUM_W'(old_mag) + SUM_W'(mag_q);
          valid[slot] <= 1'b1;
          if (slot == SLOT_W'(WINDOW - 1)) begin
            slot <= '0;
          end else begin
            slot <= slot + 1'b1;
          end
          state <= W_CLASSIFY;
        end
        W_CLASSIFY: begin
          done  <= 1'b1;
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  // Payload registers: captured magnitude, limits and the classified result.
  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        if (start) begin
          rd_valid <= valid[slot];
          mag_q    <= magnitude;
        end
      end
      W_UPDATE: begin
        hi_lim <= SUM_W'(high_threshold) * SUM_W'(WINDOW);
        lo_lim <= SUM_W'(low_threshold) * SUM_W'(WINDOW);
      end
      W_CLASSIFY: begin
        // The high threshold takes precedence over the low one.
        if (running_sum > hi_lim) begin
          level <= LEVEL_HIGH;
        end else if (running_sum > lo_lim) begin
          level <= LEVEL_ACTIVE;
        end else begin
          level <= LEVEL_INACTIVE;
        end
        if (sum_ext > EXT_W'(WSUM_MAX)) begin
          sum_out <= WSUM_MAX;
        end else begin
          sum_out <= sum_ext[WSUM_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign status.done       = done;
  assign status.level      = level;
  assign status.window_sum = sum_out;

endmodule
